FILE: src/ibec_pkg.sv
// Package with the types and constants of the inventory block-entry counter.
`default_nettype none
package ibec_pkg;

  localparam int unsigned CNT_W      = 17;
  localparam int unsigned BYTES_W    = 23;
  localparam int unsigned IDX_W      = 6;
  localparam int unsigned DECL_W     = 64;
  localparam int unsigned TYPE_W     = 32;
  localparam int unsigned LEFT_W     = 4;

  localparam logic [BYTES_W-1:0] MAX_PAYLOAD = 23'd4194304;
  localparam logic [IDX_W-1:0]   ENTRY_BYTES = 6'd36;
  localparam logic [CNT_W-1:0]   CNT_MAX     = 17'h1FFFF;

  localparam logic [7:0] PREFIX_U16 = 8'hfd;
  localparam logic [7:0] PREFIX_U32 = 8'hfe;

  localparam logic [TYPE_W-1:0] WITNESS_MASK = 32'hBFFF_FFFF;
  localparam logic [TYPE_W-1:0] KIND_BLOCK    = 32'd2;
  localparam logic [TYPE_W-1:0] KIND_FILTERED = 32'd3;
  localparam logic [TYPE_W-1:0] KIND_CMPCT    = 32'd4;

  typedef enum logic [1:0] {
    PH_PREFIX = 2'd0,
    PH_COUNT  = 2'd1,
    PH_ENTRY  = 2'd2
  } phase_t;

  typedef struct packed {
    logic [CNT_W-1:0] block_hits;
    logic [CNT_W-1:0] entry_total;
    logic             payload_ok;
  } result_t;

endpackage
`default_nettype wire

FILE: src/ibec_ifs.sv
// Valid/ready channel interfaces for the input bytes and the result beats.
`default_nettype none
interface ibec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ibec_out_if;
  logic                         valid;
  logic                         ready;
  logic [ibec_pkg::CNT_W-1:0]   block_hits;
  logic [ibec_pkg::CNT_W-1:0]   entry_total;
  logic                         payload_ok;

  modport source (output valid, output block_hits, output entry_total,
                  output payload_ok, input ready);
  modport sink (input valid, input block_hits, input entry_total,
                input payload_ok, output ready);
endinterface
`default_nettype wire

FILE: src/inv_block_entry_counter.sv
// Top level of the inventory payload block-entry counter.
//
// The in_ch channel carries one payload byte per beat, with last_byte set
// on the final byte of a payload. The out_ch channel carries one result
// beat per payload: the number of block entries, the number of complete
// entries and an ok flag; both counts read zero when the payload is bad.
// Each input beat updates the parser state in the cycle it is accepted, so
// the block takes one byte per cycle. The result of a payload appears in
// the output register in the cycle after its final byte is accepted. The
// output register is the only buffer: while it holds a result that the
// receiver has not taken, in_ch.ready is low; a result taken in the same
// cycle frees it, so bytes keep flowing at one per cycle under no stall.
// After a final byte the parser returns to its start state and the next
// byte begins a new payload. Reset clears the parser and empties the
// output register.
`default_nettype none
module inv_block_entry_counter (
  input  wire logic         clk,
  input  wire logic         rst_n,
  ibec_in_if.sink           in_ch,
  ibec_out_if.source        out_ch
);

  logic               step;
  logic               out_valid_r;
  ibec_pkg::result_t  result;
  ibec_pkg::result_t  out_data_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign step        = in_ch.valid && in_ch.ready;

  ibec_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step && in_ch.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && in_ch.last_byte) begin
      out_data_r <= result;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.block_hits  = out_data_r.block_hits;
  assign out_ch.entry_total = out_data_r.entry_total;
  assign out_ch.payload_ok  = out_data_r.payload_ok;

endmodule
`default_nettype wire

FILE: src/ibec_core.sv
// Parser state and per-byte update that decodes the count and walks the entries.
`default_nettype none
module ibec_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              step,
  input  wire logic [7:0]        data_byte,
  input  wire logic              last_byte,
  output ibec_pkg::result_t      result
);

  ibec_pkg::phase_t                  phase_r, phase_nxt;
  logic [ibec_pkg::LEFT_W-1:0]       left_r, left_nxt;
  logic [ibec_pkg::DECL_W-1:0]       decl_r, decl_nxt;
  logic [ibec_pkg::IDX_W-1:0]        idx_r, idx_nxt;
  logic [ibec_pkg::TYPE_W-1:0]       type_r, type_nxt;
  logic [ibec_pkg::CNT_W-1:0]        seen_r, seen_nxt;
  logic [ibec_pkg::CNT_W-1:0]        match_r, match_nxt;
  logic [ibec_pkg::BYTES_W-1:0]      bytes_r, bytes_nxt;
  logic                              err_r, err_nxt;

  always_comb begin
    logic [ibec_pkg::TYPE_W-1:0] masked;
    logic                        ok;
    phase_nxt = phase_r;
    left_nxt  = left_r;
    decl_nxt  = decl_r;
    idx_nxt   = idx_r;
    type_nxt  = type_r;
    seen_nxt  = seen_r;
    match_nxt = match_r;
    bytes_nxt = bytes_r;
    err_nxt   = err_r;
    masked    = '0;

    if (bytes_r <= ibec_pkg::MAX_PAYLOAD) begin
      bytes_nxt = bytes_r + 1'b1;
    end
    if (bytes_nxt > ibec_pkg::MAX_PAYLOAD) begin
      err_nxt = 1'b1;
    end

    case (phase_r)
      ibec_pkg::PH_COUNT: begin
        decl_nxt[{idx_r[2:0], 3'b000} +: 8] = decl_r[{idx_r[2:0], 3'b000} +: 8] | data_byte;
        idx_nxt = idx_r + 1'b1;
        if (left_r != '0) begin
          left_nxt = left_r - 1'b1;
        end
        if (left_nxt == '0) begin
          phase_nxt = ibec_pkg::PH_ENTRY;
          idx_nxt   = '0;
        end
      end
      ibec_pkg::PH_ENTRY: begin
        if (idx_r < 6'd4) begin
          type_nxt[{idx_r[1:0], 3'b000} +: 8] = type_r[{idx_r[1:0], 3'b000} +: 8] | data_byte;
        end
        idx_nxt = idx_r + 1'b1;
        if (idx_nxt >= ibec_pkg::ENTRY_BYTES) begin
          if (({47'b0, seen_r} >= decl_r) || (seen_r >= ibec_pkg::CNT_MAX)) begin
            err_nxt = 1'b1;
          end else begin
            seen_nxt = seen_r + 1'b1;
            masked   = type_nxt & ibec_pkg::WITNESS_MASK;
            if ((masked == ibec_pkg::KIND_BLOCK) || (masked == ibec_pkg::KIND_FILTERED) ||
                (masked == ibec_pkg::KIND_CMPCT)) begin
              match_nxt = match_r + 1'b1;
            end
          end
          idx_nxt  = '0;
          type_nxt = '0;
        end
      end
      default: begin
        idx_nxt  = '0;
        type_nxt = '0;
        if (data_byte < ibec_pkg::PREFIX_U16) begin
          decl_nxt  = {56'b0, data_byte};
          phase_nxt = ibec_pkg::PH_ENTRY;
        end else begin
          decl_nxt  = '0;
          phase_nxt = ibec_pkg::PH_COUNT;
          if (data_byte == ibec_pkg::PREFIX_U16) begin
            left_nxt = 4'd2;
          end else if (data_byte == ibec_pkg::PREFIX_U32) begin
            left_nxt = 4'd4;
          end else begin
            left_nxt = 4'd8;
          end
        end
      end
    endcase

    ok = !err_nxt && (phase_nxt == ibec_pkg::PH_ENTRY) && (idx_nxt == '0) &&
         ({47'b0, seen_nxt} == decl_nxt);
    result.block_hits  = ok ? match_nxt : '0;
    result.entry_total = ok ? seen_nxt : '0;
    result.payload_ok  = ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && last_byte)) begin
      phase_r <= ibec_pkg::PH_PREFIX;
      left_r  <= '0;
      decl_r  <= '0;
      idx_r   <= '0;
      type_r  <= '0;
      seen_r  <= '0;
      match_r <= '0;
      bytes_r <= '0;
      err_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      left_r  <= left_nxt;
      decl_r  <= decl_nxt;
      idx_r   <= idx_nxt;
      type_r  <= type_nxt;
      seen_r  <= seen_nxt;
      match_r <= match_nxt;
      bytes_r <= bytes_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule
`default_nettype wire
